FILE: design/smx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine execute package
// Shared opcodes, status codes, request and response types, and the
// command and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package smx_pkg;

  // Default sizes for the top level parameters.
  localparam int unsigned STACK_DEPTH_DEF = 256;
  localparam int unsigned PC_WIDTH_DEF    = 16;

  // Instruction opcodes.
  localparam logic [3:0] OP_PUSH       = 4'd0;
  localparam logic [3:0] OP_POP        = 4'd1;
  localparam logic [3:0] OP_SWAP       = 4'd2;
  localparam logic [3:0] OP_PRINTSTACK = 4'd3;
  localparam logic [3:0] OP_DUP        = 4'd4;
  localparam logic [3:0] OP_GET        = 4'd5;
  localparam logic [3:0] OP_PRINT      = 4'd6;
  localparam logic [3:0] OP_BTRUE      = 4'd7;
  localparam logic [3:0] OP_CMPI       = 4'd8;
  localparam logic [3:0] OP_HALT       = 4'd9;
  localparam logic [3:0] OP_ADD        = 4'd10;
  localparam logic [3:0] OP_SUB        = 4'd11;
  localparam logic [3:0] OP_MULT       = 4'd12;
  localparam logic [3:0] OP_NOT        = 4'd13;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNDER   = 3'd1;
  localparam logic [2:0] ST_HALT    = 3'd2;
  localparam logic [2:0] ST_ILLEGAL = 3'd3;
  localparam logic [2:0] ST_OVER    = 3'd4;

  // One instruction request.
  typedef struct packed {
    logic        [3:0]  action;
    logic signed [31:0] immediate;
    logic signed [31:0] entered_value;
  } req_t;

  // One instruction result.
  typedef struct packed {
    logic        [15:0] next_pc;
    logic        [2:0]  status;
    logic               print_valid;
    logic signed [31:0] print_value;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;  // latch the request operands
    logic       commit;   // execute and write back
    logic [3:0] op;
    logic [2:0] status;
  } cmd_t;

  // Stack depth flags from the datapath to the controller.
  typedef struct packed {
    logic ge1;
    logic ge2;
    logic full;
  } dp_status_t;

endpackage

FILE: design/smx_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine controller
// Sequences each request through operand fetch and execution, decodes the
// opcode and decides the status from the stack depth flags.
// ----------------------------------------------------------------------------
module smx_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [3:0]        action_i,
  input  smx_pkg::dp_status_t stat_i,
  output logic              busy_o,
  output smx_pkg::cmd_t     cmd_o
);
  import smx_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic       state_q, state_d;
  logic [3:0] op_q, op_d;
  logic       accept;
  logic       need1, need2, grow, illegal;
  logic [2:0] status;

  assign busy_o = (state_q == S_EXEC);
  assign accept = start_i && !busy_o;

  // State sequence: a request is taken in idle and executes in the next cycle.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
          op_d    = action_i;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_PUSH;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Opcode decode: operands needed, stack growth and illegal opcodes.
  always_comb begin
    need1   = 1'b0;
    need2   = 1'b0;
    grow    = 1'b0;
    illegal = 1'b0;
    unique case (op_q) inside
      OP_PUSH, OP_GET: begin
        grow = 1'b1;
      end
      OP_DUP, OP_CMPI: begin
        need1 = 1'b1;
        grow  = 1'b1;
      end
      OP_POP, OP_PRINTSTACK, OP_PRINT, OP_BTRUE, OP_NOT: begin
        need1 = 1'b1;
      end
      OP_SWAP, OP_ADD, OP_SUB, OP_MULT: begin
        need2 = 1'b1;
      end
      OP_HALT: begin
        grow = 1'b0;
      end
      default: begin
        illegal = 1'b1;
      end
    endcase
  end

  // Status decision in priority order.
  always_comb begin
    if (illegal) begin
      status = ST_ILLEGAL;
    end else if (op_q == OP_HALT) begin
      status = ST_HALT;
    end else if ((need1 && !stat_i.ge1) || (need2 && !stat_i.ge2)) begin
      status = ST_UNDER;
    end else if (grow && stat_i.full) begin
      status = ST_OVER;
    end else begin
      status = ST_OK;
    end
  end

  assign cmd_o.capture = accept;
  assign cmd_o.commit  = (state_q == S_EXEC);
  assign cmd_o.op      = op_q;
  assign cmd_o.status  = status;

  // An accepted request executes in the very next cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> cmd_o.commit)
    else $error("accepted request did not execute next cycle");

  // Execution lasts a single cycle.
  a_commit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> !cmd_o.commit)
    else $error("execution held for more than one cycle");

endmodule

FILE: design/smx_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine datapath
// Holds the program counter, the stack depth, the top of stack register and
// the stack memory for the entries below the top, and forms the result.
// ----------------------------------------------------------------------------
module smx_datapath #(
  parameter int unsigned STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
  parameter int unsigned PC_WIDTH    = smx_pkg::PC_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smx_pkg::req_t       req_i,
  input  smx_pkg::cmd_t       cmd_i,
  output smx_pkg::dp_status_t stat_o,
  output logic                done_o,
  output smx_pkg::rsp_t       rsp_o
);
  import smx_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  logic [31:0]          mem [STACK_DEPTH];
  logic [PC_WIDTH-1:0]  pc_q, pc_d;
  logic [DW-1:0]        depth_q, depth_d;
  logic [31:0]          tos_q, tos_d;
  logic [31:0]          nos_q;
  logic [31:0]          imm_q, ent_q;
  logic                 done_q;
  rsp_t                 rsp_q, rsp_d;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 wr_en;
  logic [31:0]          wr_data;
  logic [DW-1:0]        depth_m1, depth_m2;
  logic [PC_WIDTH-1:0]  pc_inc;
  logic [31:0]          sum, diff, prod;
  logic [31:0]          pc_wide;

  assign depth_m1 = depth_q - DW'(1);
  assign depth_m2 = depth_q - DW'(2);
  assign pc_inc   = pc_q + PC_WIDTH'(1);
  assign sum      = nos_q + tos_q;
  assign diff     = nos_q - tos_q;
  assign prod     = nos_q * tos_q;

  // Depth flags for the controller.
  assign stat_o.ge1  = (depth_q >= DW'(1));
  assign stat_o.ge2  = (depth_q >= DW'(2));
  assign stat_o.full = (depth_q >= DW'(STACK_DEPTH));

  // The entry under the top is read every cycle, so it is ready at execution.
  assign rd_addr = stat_o.ge2 ? depth_m2[AW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    nos_q <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Request operands are latched on acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      imm_q <= req_i.immediate;
      ent_q <= req_i.entered_value;
    end
  end

  // Execution: next state, memory write and result.
  always_comb begin
    pc_d    = pc_q;
    depth_d = depth_q;
    tos_d   = tos_q;
    wr_en   = 1'b0;
    wr_addr = depth_m1[AW-1:0];
    wr_data = tos_q;
    rsp_d.status      = cmd_i.status;
    rsp_d.print_valid = 1'b0;
    rsp_d.print_value = '0;
    if (cmd_i.commit) begin
      case (cmd_i.status)
        ST_OK: begin
          pc_d = pc_inc;
          case (cmd_i.op) inside
            OP_PUSH, OP_GET: begin
              // The old top moves into memory when there is one.
              wr_en   = stat_o.ge1;
              tos_d   = (cmd_i.op == OP_GET) ? ent_q : imm_q;
              depth_d = depth_q + DW'(1);
            end
            OP_POP: begin
              tos_d   = nos_q;
              depth_d = depth_m1;
            end
            OP_SWAP: begin
              wr_en   = 1'b1;
              wr_addr = depth_m2[AW-1:0];
              tos_d   = nos_q;
            end
            OP_DUP: begin
              wr_en   = 1'b1;
              depth_d = depth_q + DW'(1);
            end
            OP_PRINT: begin
              rsp_d.print_valid = 1'b1;
              rsp_d.print_value = tos_q;
            end
            OP_BTRUE: begin
              tos_d   = nos_q;
              depth_d = depth_m1;
              if (tos_q != '0) begin
                pc_d = pc_q + imm_q[PC_WIDTH-1:0];
              end
            end
            OP_CMPI: begin
              wr_en   = 1'b1;
              tos_d   = (tos_q == imm_q) ? 32'd1 : 32'd0;
              depth_d = depth_q + DW'(1);
            end
            OP_ADD: begin
              tos_d   = sum;
              depth_d = depth_m1;
            end
            OP_SUB: begin
              tos_d   = diff;
              depth_d = depth_m1;
            end
            OP_MULT: begin
              tos_d   = prod;
              depth_d = depth_m1;
            end
            OP_NOT: begin
              tos_d = (tos_q == '0) ? 32'd1 : 32'd0;
            end
            default: begin
              tos_d = tos_q;
            end
          endcase
        end
        ST_HALT: begin
          pc_d    = pc_inc;
          depth_d = '0;
        end
        default: begin
          pc_d = pc_q;
        end
      endcase
    end
    pc_wide       = 32'(pc_d);
    rsp_d.next_pc = pc_wide[15:0];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= '0;
      depth_q <= '0;
      done_q  <= 1'b0;
    end else begin
      pc_q    <= pc_d;
      depth_q <= depth_d;
      done_q  <= cmd_i.commit;
    end
  end

  // Top of stack and result registers.
  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // The stack never holds more than its capacity.
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  // A result appears only in the cycle after an execution.
  a_done_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cmd_i.commit))
    else $error("result strobe without execution");

  // A rejected instruction leaves the stack and the program counter alone.
  a_reject_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && (cmd_i.status == ST_UNDER || cmd_i.status == ST_OVER ||
                     cmd_i.status == ST_ILLEGAL)
    |=> $stable(depth_q) && $stable(pc_q))
    else $error("rejected instruction changed state");

endmodule

FILE: design/stack_machine_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine execute
// Executes one stack machine instruction per request and reports the next
// program counter, a status and an optional printed value.
// ----------------------------------------------------------------------------
// A request is accepted at a clock edge where start is high and busy is low,
// the following cycle executes it (busy high), and the result is on rsp_o
// with done_o high for exactly one cycle after that, during which busy is
// already low and the next request can be accepted. The entry under the top
// of stack is read from the stack memory in the cycle before execution and
// any write back happens at the end of execution. Results cannot be held off;
// the receiver must take each one in the cycle it is shown. No clearing pass
// runs after reset; requests are accepted from the first cycle.
module stack_machine_execute #(
  parameter int unsigned STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
  parameter int unsigned PC_WIDTH    = smx_pkg::PC_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  smx_pkg::req_t req_i,
  output logic          busy,
  output logic          done_o,
  output smx_pkg::rsp_t rsp_o
);
  import smx_pkg::*;

  cmd_t       cmd;
  dp_status_t dp_stat;

  // Sequencing and decode.
  smx_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (req_i.action),
    .stat_i   (dp_stat),
    .busy_o   (busy),
    .cmd_o    (cmd)
  );

  // Stack, program counter and result.
  smx_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .PC_WIDTH    (PC_WIDTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (dp_stat),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

FILE: tb/tb_stack_machine_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine execute testbench
// Drives instruction requests into the executor and checks every result
// against a cycle-free model of the program counter and stack. Directed
// corner cases come first, then a full-stack test, then random programs.
// ----------------------------------------------------------------------------
module tb_stack_machine_execute;
  import smx_pkg::*;

  localparam int unsigned STACK_DEPTH   = STACK_DEPTH_DEF;
  localparam int unsigned PC_WIDTH      = PC_WIDTH_DEF;
  localparam int          CLK_HALF      = 6;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          REPORT_MAX    = 10;
  localparam int          RANDOM_REQS   = 110;
  localparam int          QUIET_REQS    = 30;
  localparam int unsigned UNWIND_LEVELS = 32;

  // Opcodes outside the instruction set.
  localparam logic [3:0] OP_ILLEGAL_A = 4'd14;
  localparam logic [3:0] OP_ILLEGAL_B = 4'd15;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  req_t  req_i;
  logic  busy;
  logic  done_o;
  rsp_t  rsp_o;

  // Model state: program counter and stack contents.
  logic [15:0] pc_model;
  logic [31:0] stack_mem [STACK_DEPTH];
  int unsigned stack_level;

  rsp_t pending_results[$];
  int   mismatch_count;
  int   cycle_count;
  bit   idle_en;

  // All legal opcodes except halt, used to draw random instructions.
  logic [3:0] work_ops [13] = '{OP_PUSH, OP_POP, OP_SWAP, OP_PRINTSTACK, OP_DUP,
                                OP_GET, OP_PRINT, OP_BTRUE, OP_CMPI, OP_ADD,
                                OP_SUB, OP_MULT, OP_NOT};

  stack_machine_execute #(
    .STACK_DEPTH(STACK_DEPTH),
    .PC_WIDTH   (PC_WIDTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .req_i (req_i),
    .busy  (busy),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Executes one instruction on the model and returns the expected result.
  function automatic rsp_t execute_instr(req_t r);
    rsp_t        res;
    int unsigned need;
    bit          grow;
    bit          known;
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] npc;
    res   = '0;
    need  = 0;
    grow  = 1'b0;
    known = 1'b1;
    npc   = pc_model + 16'd1;
    case (r.action)
      OP_PUSH, OP_GET: grow = 1'b1;
      OP_DUP, OP_CMPI: begin
        need = 1;
        grow = 1'b1;
      end
      OP_POP, OP_PRINTSTACK, OP_PRINT, OP_BTRUE, OP_NOT: need = 1;
      OP_SWAP, OP_ADD, OP_SUB, OP_MULT: need = 2;
      OP_HALT: need = 0;
      default: known = 1'b0;
    endcase
    res.status = ST_OK;
    if (!known) begin
      res.status = ST_ILLEGAL;
    end else if (r.action != OP_HALT) begin
      if (stack_level < need) res.status = ST_UNDER;
      else if (grow && stack_level >= STACK_DEPTH) res.status = ST_OVER;
    end
    if (res.status != ST_OK) begin
      res.next_pc = pc_model;
      return res;
    end
    x = (stack_level >= 1) ? stack_mem[stack_level - 1] : '0;
    y = (stack_level >= 2) ? stack_mem[stack_level - 2] : '0;
    case (r.action)
      OP_PUSH: begin
        stack_mem[stack_level] = r.immediate;
        stack_level++;
      end
      OP_GET: begin
        stack_mem[stack_level] = r.entered_value;
        stack_level++;
      end
      OP_POP: stack_level--;
      OP_SWAP: begin
        stack_mem[stack_level - 1] = y;
        stack_mem[stack_level - 2] = x;
      end
      OP_DUP: begin
        stack_mem[stack_level] = x;
        stack_level++;
      end
      OP_PRINT: begin
        res.print_valid = 1'b1;
        res.print_value = x;
      end
      OP_BTRUE: begin
        stack_level--;
        // The target wraps with the counter, so only the low offset bits matter.
        if (x != '0) npc = pc_model + r.immediate[15:0];
      end
      OP_CMPI: begin
        stack_mem[stack_level] = (x == r.immediate) ? 32'd1 : 32'd0;
        stack_level++;
      end
      OP_HALT: begin
        stack_level = 0;
        res.status  = ST_HALT;
      end
      OP_ADD: begin
        stack_level--;
        stack_mem[stack_level - 1] = y + x;
      end
      OP_SUB: begin
        stack_level--;
        stack_mem[stack_level - 1] = y - x;
      end
      OP_MULT: begin
        stack_level--;
        stack_mem[stack_level - 1] = y * x;
      end
      OP_NOT: stack_mem[stack_level - 1] = (x == '0) ? 32'd1 : 32'd0;
      default: ;
    endcase
    pc_model    = npc;
    res.next_pc = npc;
    return res;
  endfunction

  function automatic req_t make_req(logic [3:0] op, logic [31:0] imm, logic [31:0] ent);
    req_t r;
    r.action        = op;
    r.immediate     = imm;
    r.entered_value = ent;
    return r;
  endfunction

  // Sends one request, waits for it to be taken, and records its result.
  task automatic issue_instr(req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(execute_instr(r));
    // Random sender gaps while idle gaps are enabled.
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Result checker: each strobed result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("ERROR: result with no request pending: pc=%h status=%0d",
                   rsp_o.next_pc, rsp_o.status);
      end else begin
        want = pending_results.pop_front();
        if (rsp_o.next_pc !== want.next_pc || rsp_o.status !== want.status ||
            rsp_o.print_valid !== want.print_valid ||
            rsp_o.print_value !== want.print_value) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("ERROR: exp pc=%h st=%0d pv=%b val=%h, got pc=%h st=%0d pv=%b val=%h",
                     want.next_pc, want.status, want.print_valid, want.print_value,
                     rsp_o.next_pc, rsp_o.status, rsp_o.print_valid, rsp_o.print_value);
        end
      end
    end
  end

  // Corner cases: underflow, illegal opcodes, value extremes, wrap, branches, halt.
  task automatic test_directed();
    issue_instr(make_req(OP_POP, 32'd0, 32'd0));
    issue_instr(make_req(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    issue_instr(make_req(OP_ILLEGAL_A, 32'd5, 32'd0));
    issue_instr(make_req(OP_ILLEGAL_B, 32'h8000_0000, 32'h7FFF_FFFF));
    issue_instr(make_req(OP_PUSH, 32'h7FFF_FFFF, 32'd0));
    issue_instr(make_req(OP_SWAP, 32'd0, 32'd0));
    issue_instr(make_req(OP_PUSH, 32'h8000_0000, 32'hFFFF_FFFF));
    issue_instr(make_req(OP_SWAP, 32'd0, 32'd0));
    issue_instr(make_req(OP_ADD, 32'd0, 32'd0));
    issue_instr(make_req(OP_DUP, 32'd0, 32'd0));
    issue_instr(make_req(OP_MULT, 32'd0, 32'd0));
    issue_instr(make_req(OP_GET, 32'd0, 32'h8000_0000));
    issue_instr(make_req(OP_SUB, 32'd0, 32'd0));
    issue_instr(make_req(OP_PRINT, 32'd0, 32'd0));
    issue_instr(make_req(OP_CMPI, 32'h8000_0001, 32'd0));
    issue_instr(make_req(OP_NOT, 32'd0, 32'd0));
    issue_instr(make_req(OP_PRINTSTACK, 32'd0, 32'd0));
    // A zero top falls through; a nonzero top branches back past address zero.
    issue_instr(make_req(OP_BTRUE, -32'sd5, 32'd0));
    issue_instr(make_req(OP_BTRUE, -32'sd100, 32'd0));
    issue_instr(make_req(OP_GET, 32'd0, 32'h7FFF_FFFF));
    issue_instr(make_req(OP_BTRUE, 32'h7FFF_FFFF, 32'd0));
    issue_instr(make_req(OP_HALT, 32'd0, 32'd0));
    issue_instr(make_req(OP_HALT, 32'd0, 32'd0));
    issue_instr(make_req(OP_PRINTSTACK, 32'd0, 32'd0));
  endtask

  // Fills the stack to capacity, hits overflow, unwinds the upper part with
  // printing and then clears the rest with a halt.
  task automatic test_full_stack();
    logic [3:0] op;
    while (stack_level < STACK_DEPTH) begin
      case ($urandom_range(0, 3))
        0:       op = OP_PUSH;
        1:       op = OP_GET;
        2:       op = OP_DUP;
        default: op = OP_CMPI;
      endcase
      issue_instr(make_req(op, $urandom, $urandom));
    end
    issue_instr(make_req(OP_PUSH, $urandom, $urandom));
    issue_instr(make_req(OP_GET, $urandom, $urandom));
    issue_instr(make_req(OP_DUP, $urandom, $urandom));
    issue_instr(make_req(OP_CMPI, $urandom, $urandom));
    issue_instr(make_req(OP_SWAP, 32'd0, 32'd0));
    issue_instr(make_req(OP_NOT, 32'd0, 32'd0));
    issue_instr(make_req(OP_POP, 32'd0, 32'd0));
    issue_instr(make_req(OP_GET, 32'd0, $urandom));
    while (stack_level > STACK_DEPTH - UNWIND_LEVELS) begin
      if ($urandom_range(0, 2) == 0) issue_instr(make_req(OP_PRINT, 32'd0, 32'd0));
      case ($urandom_range(0, 5))
        0:       op = OP_POP;
        1:       op = OP_ADD;
        2:       op = OP_SUB;
        3:       op = OP_MULT;
        4:       op = OP_BTRUE;
        default: op = OP_SWAP;
      endcase
      issue_instr(make_req(op, $urandom_range(0, 16) - 8, 32'd0));
    end
    issue_instr(make_req(OP_HALT, 32'd0, 32'd0));
  endtask

  // Random programs: mostly legal instructions with the stack kept populated.
  task automatic test_random();
    req_t r;
    int   pick;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(0, 99);
      r    = make_req(OP_PUSH, $urandom, $urandom);
      if (pick < 3) begin
        r.action = $urandom_range(0, 1) ? OP_ILLEGAL_A : OP_ILLEGAL_B;
      end else if (pick < 5) begin
        r.action = OP_HALT;
      end else if (stack_level < 2 && pick < 60) begin
        r.action = $urandom_range(0, 1) ? OP_PUSH : OP_GET;
      end else begin
        r.action = work_ops[$urandom_range(0, 12)];
      end
      // Small operands make compare hits and short branches likely.
      if ($urandom_range(0, 2) == 0) r.immediate = $urandom_range(0, 16) - 8;
      if ($urandom_range(0, 3) == 0) r.entered_value = $urandom_range(0, 3);
      if (r.action == OP_CMPI && stack_level > 0 && $urandom_range(0, 1) == 0)
        r.immediate = stack_mem[stack_level - 1];
      if (r.action == OP_BTRUE && $urandom_range(0, 3) != 0)
        r.immediate = $urandom_range(0, 64) - 32;
      if (n == RANDOM_REQS / 2) begin
        // Hold the sender until the executor has returned every result.
        wait_results_drained();
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      if (n == RANDOM_REQS - QUIET_REQS) idle_en = 1'b0;
      issue_instr(r);
    end
  endtask

  // Test sequence.
  initial begin
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    req_i          <= '0;
    pc_model        = '0;
    stack_level     = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    idle_en         = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_stack();
    test_random();
    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: stack_machine_execute.f
design/smx_pkg.sv
design/smx_ctrl.sv
design/smx_datapath.sv
design/stack_machine_execute.sv
tb/tb_stack_machine_execute.sv
